### rtl/atbs_pkg.sv
`default_nettype none

package atbs_pkg;

    // Field and state widths.
    localparam int CODE_W     = 12;
    localparam int LEVEL_W    = 20;
    localparam int FRAC_W     = 8;
    localparam int WEIGHT_W   = 9;
    localparam int HASH_W     = 8;
    localparam int GSUM_W     = 14;
    localparam int CMP_W      = GSUM_W + FRAC_W;
    localparam int BITCNT_W   = 6;
    localparam int MSUM_W     = 17;
    localparam int FRAME_BITS = 32;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Reset values of the configuration registers.
    localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RST = 9'd13;
    localparam logic [WEIGHT_W-1:0] THR_WEIGHT_RST = 9'd128;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = 9'd256;
    localparam logic [HASH_W-1:0]   SEED_RST       = 8'd170;
    localparam logic [HASH_W-1:0]   OFFSET_RST     = 8'd1;

    // Reset values of the level state, 12.8 fixed point; the message low bound is a 12-bit code.
    localparam logic [LEVEL_W-1:0]  RUN_MIN_RST  = 20'hFFF00;
    localparam logic [LEVEL_W-1:0]  RUN_MAX_RST  = 20'h00000;
    localparam logic [LEVEL_W-1:0]  THR_RST      = 20'h80000;
    localparam logic [CODE_W-1:0]   MSG_LOW_RST  = 12'hFFF;

    // Register map, one word per register.
    typedef enum logic [1:0] {
        REG_EMA_WEIGHT = 2'd0,
        REG_THR_WEIGHT = 2'd1,
        REG_HASH_SEED  = 2'd2,
        REG_HASH_OFFS  = 2'd3
    } t_reg_idx;

    // One closed sample group, handed from the front end to the back end.
    typedef struct packed {
        logic [LEVEL_W-1:0] run_min;
        logic [LEVEL_W-1:0] run_max;
        logic [GSUM_W-1:0]  group_sum;
    } t_group;

    // One per-bit result.
    typedef struct packed {
        logic [FRAME_BITS-1:0] message_bits;
        logic [BITCNT_W-1:0]   bit_index;
        logic [CODE_W-1:0]     bit_level;
        logic [CODE_W-1:0]     message_min;
        logic [CODE_W-1:0]     message_max;
        logic [MSUM_W-1:0]     message_level_sum;
        logic [LEVEL_W-1:0]    threshold_level;
        logic [LEVEL_W-1:0]    signal_span;
        logic                  last;
        logic                  frame_valid;
    } t_result;

    // Exponential smoothing step, rounding half up:
    // (old*(256-w) + target*w + 128) >> 8.
    function automatic logic [LEVEL_W-1:0] smooth(
        input logic [LEVEL_W-1:0]  old_val,
        input logic [LEVEL_W-1:0]  target,
        input logic [WEIGHT_W-1:0] w
    );
        logic [WEIGHT_W-1:0]           w_old;
        logic [LEVEL_W+WEIGHT_W:0]     acc;
        w_old = WEIGHT_MAX - w;
        acc   = (LEVEL_W+WEIGHT_W+1)'(old_val) * (LEVEL_W+WEIGHT_W+1)'(w_old)
              + (LEVEL_W+WEIGHT_W+1)'(target) * (LEVEL_W+WEIGHT_W+1)'(w)
              + (LEVEL_W+WEIGHT_W+1)'(128);
        return acc[LEVEL_W+FRAC_W-1:FRAC_W];
    endfunction

    // Expected check byte for one id byte.
    function automatic logic [HASH_W-1:0] check_byte(
        input logic [HASH_W-1:0] id,
        input logic [HASH_W-1:0] seed,
        input logic [HASH_W-1:0] offs
    );
        return (id ^ seed) + offs;
    endfunction

endpackage

`default_nettype wire

### rtl/atbs_fifo.sv
`default_nettype none

module atbs_fifo import atbs_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_group i_item,
    output logic        o_full,
    output logic        o_valid,
    output t_group      o_item,
    input  wire logic   i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_group             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

### rtl/atbs_front.sv
`default_nettype none

module atbs_front import atbs_pkg::*; #(
    parameter int SAMPLES_PER_SYMBOL = 3
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [CODE_W-1:0]   i_sample,
    input  wire logic [WEIGHT_W-1:0] i_ema_weight,
    input  wire logic                i_queue_full,
    output logic                     o_push,
    output t_group                   o_group
);

    localparam int CNT_W = $clog2(SAMPLES_PER_SYMBOL + 1);

    logic [LEVEL_W-1:0] r_run_min, n_run_min;
    logic [LEVEL_W-1:0] r_run_max, n_run_max;
    logic [GSUM_W-1:0]  r_group_sum, n_group_sum;
    logic [CNT_W-1:0]   r_group_cnt;
    logic [LEVEL_W-1:0] level_in;
    logic               accept;
    logic               group_done;

    assign o_ready    = !i_queue_full;
    assign accept     = i_valid && o_ready;
    assign level_in   = {i_sample, FRAC_W'(0)};
    assign group_done = (r_group_cnt == CNT_W'(SAMPLES_PER_SYMBOL - 1));

    // Smoothed running extremes, clamped so the sample stays inside them.
    always_comb begin
        n_run_min = smooth(r_run_min, level_in, i_ema_weight);
        n_run_max = smooth(r_run_max, level_in, i_ema_weight);
        if (level_in < n_run_min) begin
            n_run_min = level_in;
        end
        if (level_in > n_run_max) begin
            n_run_max = level_in;
        end
        n_group_sum = r_group_sum + GSUM_W'(i_sample);
    end

    // A closing sample pushes the finished group into the queue.
    assign o_push            = accept && group_done;
    assign o_group.run_min   = n_run_min;
    assign o_group.run_max   = n_run_max;
    assign o_group.group_sum = n_group_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_min   <= RUN_MIN_RST;
            r_run_max   <= RUN_MAX_RST;
            r_group_sum <= '0;
            r_group_cnt <= '0;
        end else if (accept) begin
            r_run_min <= n_run_min;
            r_run_max <= n_run_max;
            if (group_done) begin
                r_group_sum <= '0;
                r_group_cnt <= '0;
            end else begin
                r_group_sum <= n_group_sum;
                r_group_cnt <= r_group_cnt + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/atbs_back.sv
`default_nettype none

module atbs_back import atbs_pkg::*; #(
    parameter int SAMPLES_PER_SYMBOL = 3
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_group_valid,
    input  wire t_group              i_group,
    output logic                     o_pop,
    input  wire logic [WEIGHT_W-1:0] i_thr_weight,
    input  wire logic [HASH_W-1:0]   i_hash_seed,
    input  wire logic [HASH_W-1:0]   i_hash_offs,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output t_result                  o_result
);

    // Reciprocal of the group size for the average, 16 fraction bits.
    localparam int RECIP_W = 17;
    localparam int PROD_W  = GSUM_W + RECIP_W;
    localparam int RECIP   = 65536 / SAMPLES_PER_SYMBOL;
    localparam int REM_W   = GSUM_W + 2;

    // Stage one: threshold update, span and first quotient estimate.
    logic               r_s1_valid;
    logic [LEVEL_W-1:0] r_thr;
    logic [GSUM_W-1:0]  r_s1_gsum;
    logic [GSUM_W-1:0]  r_s1_quot;
    logic [LEVEL_W-1:0] r_s1_span;

    // Message state.
    logic [FRAME_BITS-1:0] r_shift;
    logic [BITCNT_W-1:0]   r_bits;
    logic [CODE_W-1:0]     r_msg_low;
    logic [CODE_W-1:0]     r_msg_high;
    logic [MSUM_W-1:0]     r_msg_sum;

    // Output register.
    logic    r_out_valid;
    t_result r_out;

    logic               out_free;
    logic               s1_load;
    logic               s2_load;
    logic [LEVEL_W:0]   mid_sum;
    logic [LEVEL_W-1:0] n_thr;
    logic [PROD_W-1:0]  quot_prod;
    logic [LEVEL_W-1:0] n_span;

    logic [CMP_W-1:0]   sum_scaled;
    logic [CMP_W-1:0]   thr_scaled;
    logic               bit_val;
    logic [REM_W-1:0]   rem;
    logic [GSUM_W-1:0]  quot;
    logic [CODE_W-1:0]  level;
    t_result            n_out;

    assign out_free = !r_out_valid || i_ready;
    assign s2_load  = r_s1_valid && out_free;
    assign s1_load  = i_group_valid && (!r_s1_valid || out_free);
    assign o_pop    = s1_load;

    // Threshold smoothing toward the min/max midpoint, quotient estimate and span.
    always_comb begin
        mid_sum   = (LEVEL_W+1)'(i_group.run_min) + (LEVEL_W+1)'(i_group.run_max);
        n_thr     = smooth(r_thr, mid_sum[LEVEL_W:1], i_thr_weight);
        quot_prod = PROD_W'(i_group.group_sum) * PROD_W'(RECIP);
        n_span    = (i_group.run_max > i_group.run_min) ?
                    i_group.run_max - i_group.run_min : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_thr      <= THR_RST;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
                r_thr      <= n_thr;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_gsum <= i_group.group_sum;
            r_s1_quot <= quot_prod[GSUM_W+15:16];
            r_s1_span <= n_span;
        end
    end

    // Stage two: bit decision, exact average and message statistics.
    always_comb begin
        sum_scaled = {r_s1_gsum, FRAC_W'(0)};
        thr_scaled = CMP_W'(r_thr) * CMP_W'(SAMPLES_PER_SYMBOL);
        bit_val    = (sum_scaled > thr_scaled);
        rem        = REM_W'(r_s1_gsum)
                   - REM_W'(r_s1_quot) * REM_W'(SAMPLES_PER_SYMBOL);
        quot       = (rem >= REM_W'(SAMPLES_PER_SYMBOL)) ? r_s1_quot + 1'b1 : r_s1_quot;
        level      = quot[CODE_W-1:0];

        n_out.message_bits      = {r_shift[FRAME_BITS-2:0], bit_val};
        n_out.bit_index         = r_bits + 1'b1;
        n_out.bit_level         = level;
        n_out.message_min       = (level < r_msg_low)  ? level : r_msg_low;
        n_out.message_max       = (level > r_msg_high) ? level : r_msg_high;
        n_out.message_level_sum = r_msg_sum + MSUM_W'(level);
        n_out.threshold_level   = r_thr;
        n_out.signal_span       = r_s1_span;
        n_out.last              = (n_out.bit_index >= BITCNT_W'(FRAME_BITS));
        n_out.frame_valid       = n_out.last &&
            (n_out.message_bits[15:8] ==
                check_byte(n_out.message_bits[31:24], i_hash_seed, i_hash_offs)) &&
            (n_out.message_bits[7:0] ==
                check_byte(n_out.message_bits[23:16], i_hash_seed, i_hash_offs));
    end

    // Message state restarts after the last bit of a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= '0;
            r_bits     <= '0;
            r_msg_low  <= MSG_LOW_RST;
            r_msg_high <= '0;
            r_msg_sum  <= '0;
        end else if (s2_load) begin
            if (n_out.last) begin
                r_shift    <= '0;
                r_bits     <= '0;
                r_msg_low  <= MSG_LOW_RST;
                r_msg_high <= '0;
                r_msg_sum  <= '0;
            end else begin
                r_shift    <= n_out.message_bits;
                r_bits     <= n_out.bit_index;
                r_msg_low  <= n_out.message_min;
                r_msg_high <= n_out.message_max;
                r_msg_sum  <= n_out.message_level_sum;
            end
        end
    end

    // Output register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

### rtl/adaptive_threshold_bit_slicer_core.sv
`default_nettype none

// Adaptive-threshold bit slicer. Takes one 12-bit photodiode code per request
// and keeps smoothed running minimum and maximum levels (12.8 fixed point).
// Every SAMPLES_PER_SYMBOL samples it averages the group, moves the threshold
// toward the min/max midpoint, slices one bit and returns one result request
// with the message so far and its statistics; on the 32nd bit it checks the
// two hash bytes and starts a new message. A sample is taken every cycle while
// the group queue is not full; the per-sample min/max smoothing step sets that
// rate. The result of a bit passes, after its closing sample is accepted,
// through a small group queue, a threshold stage and the output register.
// Configuration is to be written over the APB port only while the block is idle,
// which the block does not enforce: 0x0 min/max weight (Q8, saturates at 256),
// 0x4 threshold weight (Q8), 0x8 hash seed, 0xC hash offset.
module adaptive_threshold_bit_slicer_core import atbs_pkg::*; #(
    parameter int SAMPLES_PER_SYMBOL = 3,
    parameter int QUEUE_DEPTH        = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Sample channel.
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CODE_W-1:0]     i_sample,
    // Result channel.
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [FRAME_BITS-1:0]      o_message_bits,
    output logic [BITCNT_W-1:0]        o_bit_index,
    output logic [CODE_W-1:0]          o_bit_level,
    output logic [CODE_W-1:0]          o_message_min,
    output logic [CODE_W-1:0]          o_message_max,
    output logic [MSUM_W-1:0]          o_message_level_sum,
    output logic [LEVEL_W-1:0]         o_threshold_level,
    output logic [LEVEL_W-1:0]         o_signal_span,
    output logic                       o_last,
    output logic                       o_frame_valid,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    logic [WEIGHT_W-1:0] r_ema_weight;
    logic [WEIGHT_W-1:0] r_thr_weight;
    logic [HASH_W-1:0]   r_hash_seed;
    logic [HASH_W-1:0]   r_hash_offs;

    logic                cfg_write;
    t_reg_idx            cfg_idx;
    logic [WEIGHT_W-1:0] wdata_weight;

    logic                queue_push;
    logic                queue_full;
    logic                queue_valid;
    logic                queue_pop;
    t_group              front_group;
    t_group              queue_group;
    t_result             result;

    // Configuration register file.
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite && pready;
    assign cfg_idx      = t_reg_idx'(paddr[3:2]);
    assign wdata_weight = (pwdata[WEIGHT_W-1:0] > WEIGHT_MAX) ?
                          WEIGHT_MAX : pwdata[WEIGHT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema_weight <= EMA_WEIGHT_RST;
            r_thr_weight <= THR_WEIGHT_RST;
            r_hash_seed  <= SEED_RST;
            r_hash_offs  <= OFFSET_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_EMA_WEIGHT: r_ema_weight <= wdata_weight;
                REG_THR_WEIGHT: r_thr_weight <= wdata_weight;
                REG_HASH_SEED:  r_hash_seed  <= pwdata[HASH_W-1:0];
                REG_HASH_OFFS:  r_hash_offs  <= pwdata[HASH_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (cfg_idx)
            REG_EMA_WEIGHT: prdata = DATA_W'(r_ema_weight);
            REG_THR_WEIGHT: prdata = DATA_W'(r_thr_weight);
            REG_HASH_SEED:  prdata = DATA_W'(r_hash_seed);
            REG_HASH_OFFS:  prdata = DATA_W'(r_hash_offs);
            default:        prdata = '0;
        endcase
    end

    // Front end: per-sample tracking and grouping.
    atbs_front #(
        .SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .i_ema_weight (r_ema_weight),
        .i_queue_full (queue_full),
        .o_push       (queue_push),
        .o_group      (front_group)
    );

    // Queue of closed groups between the two halves.
    atbs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_item  (front_group),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_item  (queue_group),
        .i_pop   (queue_pop)
    );

    // Back end: threshold, slicing and message assembly.
    atbs_back #(
        .SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_group_valid (queue_valid),
        .i_group       (queue_group),
        .o_pop         (queue_pop),
        .i_thr_weight  (r_thr_weight),
        .i_hash_seed   (r_hash_seed),
        .i_hash_offs   (r_hash_offs),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (result)
    );

    assign o_message_bits      = result.message_bits;
    assign o_bit_index         = result.bit_index;
    assign o_bit_level         = result.bit_level;
    assign o_message_min       = result.message_min;
    assign o_message_max       = result.message_max;
    assign o_message_level_sum = result.message_level_sum;
    assign o_threshold_level   = result.threshold_level;
    assign o_signal_span       = result.signal_span;
    assign o_last              = result.last;
    assign o_frame_valid       = result.frame_valid;

    // A result always counts at least its own bit.
    a_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_bit_index != '0)
        else $error("result with zero bit index");

    // The frame ends exactly when the bit count reaches the frame length.
    a_last_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_bit_index == BITCNT_W'(FRAME_BITS))))
        else $error("last flag disagrees with bit index");

    // The hash check is only reported on the last bit.
    a_check_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> !o_frame_valid)
        else $error("frame check reported before the last bit");

    // Message statistics bracket the current bit level.
    a_stats_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_message_min <= o_bit_level) && (o_bit_level <= o_message_max))
        else $error("message min/max do not bracket the bit level");

endmodule

`default_nettype wire
